/* rtl/core/assert_macros.svh */
// Assertion macros shared by the RTL of the sorted table search block.
// Each macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every sampled edge.
`define STBS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked on the edge after the antecedent.
`define STBS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/stbs_pkg.sv */
// Package for the sorted table search block: types, codes and default sizes.
// Depends on nothing; stbs_in_if and sorted_table_binary_search_top import it.
`default_nettype none

package stbs_pkg;

    localparam int unsigned TABLE_DEPTH_DEF = 256;
    localparam int unsigned KEY_W           = 32;
    localparam int unsigned OP_W            = 2;

    // Operation codes; code 3 means nothing and gives a plain done word.
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

    typedef enum logic [1:0] {
        STATUS_DONE    = 2'd0,
        STATUS_FOUND   = 2'd1,
        STATUS_MISSING = 2'd2,
        STATUS_FULL    = 2'd3
    } status_t;

    typedef enum logic {
        SEQ_IDLE,
        SEQ_PROBE
    } seq_state_t;

endpackage

`default_nettype wire

/* rtl/core/stbs_in_if.sv */
// Command channel of the sorted table search block: operation and key.
// Depends on stbs_pkg for the field widths.
`default_nettype none

interface stbs_in_if
    import stbs_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [OP_W-1:0]         op;
    logic signed [KEY_W-1:0] key_value;

    modport source (output valid, output op, output key_value, input ready);
    modport sink   (input valid, input op, input key_value, output ready);
endinterface

`default_nettype wire

/* rtl/core/stbs_out_if.sv */
// Result channel of the sorted table search block: status and position.
// The position width follows the table depth of the block that drives it.
`default_nettype none

interface stbs_out_if #(
    parameter int unsigned POS_W = 9
) ();
    logic             valid;
    logic             ready;
    logic [1:0]       status;
    logic [POS_W-1:0] position;

    modport source (output valid, output status, output position, input ready);
    modport sink   (input valid, input status, input position, output ready);
endinterface

`default_nettype wire

/* rtl/core/sorted_table_binary_search_top.sv */
// Sorted table search block: key memory, halving search sequencer, result register.
// Depends on stbs_pkg, stbs_in_if, stbs_out_if and assert_macros.svh.
//
//   channel | dir | word contents           | handshake
//   --------+-----+-------------------------+--------------------------
//   cmd     | in  | op, key_value           | valid/ready, taken on both high
//   res     | out | status, position        | valid/ready, taken on both high
//
// Clear, append and unused ops are answered in the cycle after they are taken; a search
// sets up, then probes once per cycle, up to $clog2(TABLE_DEPTH)+1 times (nine for 256).
// The probe rate is set by the single read port of the key memory, whose registered
// data is compared and turned into the next probe address within the same cycle.
// Reset (rst_n low, asynchronous) empties the table; the key memory is not cleared.
// A command is taken whenever the sequencer is idle and the result register is empty
// or being emptied in the same cycle, so a result that waits on the result channel
// holds up the next word until it is taken.
`default_nettype none

`include "assert_macros.svh"

module sorted_table_binary_search_top
    import stbs_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    stbs_in_if.sink   cmd,
    stbs_out_if.source res
);

    // Counts and positions run from 0 to TABLE_DEPTH; addresses to TABLE_DEPTH - 1.
    localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned AW    = $clog2(TABLE_DEPTH);

    // Key memory: written on append, read once per cycle with registered data.
    logic signed [KEY_W-1:0] key_mem [TABLE_DEPTH];
    logic signed [KEY_W-1:0] rdata_reg;
    logic [AW-1:0]           rd_addr;
    logic                    mem_we;

    // Sequencer and table state.
    seq_state_t              state_reg, state_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [CNT_W-1:0]        low_reg, low_next;
    logic [CNT_W-1:0]        high_reg, high_next;
    logic [CNT_W-1:0]        mid_reg, mid_next;
    logic signed [KEY_W-1:0] key_reg, key_next;

    // Result register.
    logic                    res_valid_reg;
    status_t                 res_status_reg;
    logic [CNT_W-1:0]        res_position_reg;
    logic                    res_load;
    status_t                 res_status_next;
    logic [CNT_W-1:0]        res_position_next;

    logic                    slot_free;
    logic                    cmd_fire;
    logic                    table_full;

    // First probe: the middle of 1 .. count.
    logic [CNT_W:0]          start_sum;
    logic [CNT_W-1:0]        start_mid;
    logic [CNT_W-1:0]        start_idx;

    // Probe step: compare the key read for mid_reg and narrow the range.
    logic                    hit;
    logic                    key_below;
    logic [CNT_W-1:0]        step_low;
    logic [CNT_W-1:0]        step_high;
    logic                    range_empty;
    logic [CNT_W:0]          step_sum;
    logic [CNT_W-1:0]        step_mid;
    logic [CNT_W-1:0]        step_idx;

    assign slot_free  = !res_valid_reg || res.ready;
    assign cmd.ready  = (state_reg == SEQ_IDLE) && slot_free;
    assign cmd_fire   = cmd.valid && cmd.ready;
    assign table_full = (count_reg >= CNT_W'(TABLE_DEPTH));

    assign start_sum = {{CNT_W{1'b0}}, 1'b1} + {1'b0, count_reg};
    assign start_mid = start_sum[CNT_W:1];
    assign start_idx = start_mid - CNT_W'(1);

    assign hit       = (rdata_reg == key_reg);
    assign key_below = (key_reg < rdata_reg);

    always_comb
    begin
        if (key_below)
        begin
            step_low  = low_reg;
            step_high = mid_reg - CNT_W'(1);
        end
        else
        begin
            step_low  = mid_reg + CNT_W'(1);
            step_high = high_reg;
        end
    end

    assign range_empty = (step_low > step_high);
    assign step_sum    = {1'b0, step_low} + {1'b0, step_high};
    assign step_mid    = step_sum[CNT_W:1];
    assign step_idx    = step_mid - CNT_W'(1);

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            SEQ_IDLE:
            begin
                if (cmd_fire && (cmd.op == OP_SEARCH) && (count_reg != '0))
                begin
                    state_next = SEQ_PROBE;
                end
            end
            SEQ_PROBE:
            begin
                if (hit || range_empty)
                begin
                    state_next = SEQ_IDLE;
                end
            end
        endcase
    end

    // Datapath controls and register next values.
    always_comb
    begin
        res_load          = 1'b0;
        res_status_next   = STATUS_DONE;
        res_position_next = '0;
        count_next        = count_reg;
        low_next          = low_reg;
        high_next         = high_reg;
        mid_next          = mid_reg;
        key_next          = key_reg;
        mem_we            = 1'b0;
        rd_addr           = start_idx[AW-1:0];
        unique case (state_reg)
            SEQ_IDLE:
            begin
                if (cmd_fire)
                begin
                    unique case (cmd.op)
                        OP_CLEAR:
                        begin
                            res_load   = 1'b1;
                            count_next = '0;
                        end
                        OP_APPEND:
                        begin
                            res_load = 1'b1;
                            if (table_full)
                            begin
                                res_status_next = STATUS_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        OP_SEARCH:
                        begin
                            key_next  = cmd.key_value;
                            low_next  = CNT_W'(1);
                            high_next = count_reg;
                            mid_next  = start_mid;
                            if (count_reg == '0)
                            begin
                                res_load        = 1'b1;
                                res_status_next = STATUS_MISSING;
                            end
                        end
                        default:
                        begin
                            res_load = 1'b1;
                        end
                    endcase
                end
            end
            SEQ_PROBE:
            begin
                rd_addr = step_idx[AW-1:0];
                if (hit)
                begin
                    res_load          = 1'b1;
                    res_status_next   = STATUS_FOUND;
                    res_position_next = mid_reg;
                end
                else if (range_empty)
                begin
                    res_load        = 1'b1;
                    res_status_next = STATUS_MISSING;
                end
                else
                begin
                    low_next  = step_low;
                    high_next = step_high;
                    mid_next  = step_mid;
                end
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            key_mem[count_reg[AW-1:0]] <= cmd.key_value;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= key_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= SEQ_IDLE;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Search range and result payload need no reset.
    always_ff @(posedge clk)
    begin
        low_reg  <= low_next;
        high_reg <= high_next;
        mid_reg  <= mid_next;
        key_reg  <= key_next;
        if (res_load)
        begin
            res_status_reg   <= res_status_next;
            res_position_reg <= res_position_next;
        end
    end

    assign res.valid    = res_valid_reg;
    assign res.status   = res_status_reg;
    assign res.position = res_position_reg;

    // The probed position always lies inside the live search range.
    `STBS_ASSERT(a_mid_in_range, (state_reg != SEQ_PROBE) || ((mid_reg >= low_reg) && (mid_reg <= high_reg) && (mid_reg != '0)), "probe outside search range")
    // The entry count never passes the table depth.
    `STBS_ASSERT(a_count_bound, count_reg <= CNT_W'(TABLE_DEPTH), "entry count beyond table depth")
    // No result is left waiting while a search is under way.
    `STBS_ASSERT(a_probe_slot_empty, (state_reg != SEQ_PROBE) || !res_valid_reg, "result pending during search")
    // A search that starts on a non-empty table goes to probing with no result pending.
    `STBS_ASSERT_NEXT(a_search_start, cmd_fire && (cmd.op == OP_SEARCH) && (count_reg != '0), (state_reg == SEQ_PROBE) && !res_valid_reg, "search did not enter probing")

endmodule

`default_nettype wire
